// ===== hdl/fis_pkg.sv =====
package fis_pkg;

    localparam int DEPTH = 64;
    localparam int SLOT_W = 6;
    localparam int DIV_DW = 46;
    localparam int DIV_VW = 30;
    localparam int ROOT_W = 46;
    localparam int RAD_W = 2 * ROOT_W;

    localparam logic [27:0] RATE_SCALE = 28'd256000000;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [16:0] Q_ONE = 17'd65536;
    localparam logic [4:0] NB_RATE = 5'd28;
    localparam logic [4:0] NB_SHORT = 5'd20;

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_VSYNC = 1'b1;

    typedef struct packed {
        logic [23:0] interval_us;
        logic [23:0] busy_us;
    } t_in;

    typedef struct packed {
        logic [23:0] frame_time_us;
        logic [27:0] current_fps_q8;
        logic [23:0] average_time_us;
        logic [27:0] average_fps_q8;
        logic [16:0] pacing_quality;
        logic [19:0] wait_us;
        logic        divide_by_zero;
    } t_out;

    typedef enum logic [1:0] {
        OP_CUR = 2'd0,
        OP_AVG = 2'd1,
        OP_PER = 2'd2,
        OP_PAC = 2'd3
    } t_op;

    typedef struct packed {
        logic accept;
        logic mul_old;
        logic upd_sum;
        logic add_sq;
        logic mul_sum;
        logic sqrt_start;
        logic div_start;
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/fis_div.sv =====
module fis_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [45:0] i_dividend,
    input  logic [29:0] i_divisor,
    input  logic [4:0]  i_nbits,
    output logic        o_done,
    output logic [27:0] o_quotient
);

    logic [29:0] r_rem;
    logic [29:0] r_div;
    logic [45:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [30:0] t;
    logic        ge;

    assign t = {r_rem, r_q[45]};
    assign ge = t >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 30'(i_dividend >> i_nbits);
            r_q <= i_dividend << (6'd46 - {1'b0, i_nbits});
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? 30'(t - {1'b0, r_div}) : t[29:0];
            r_q <= {r_q[44:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_q[27:0];

endmodule

// ===== hdl/fis_sqrt.sv =====
module fis_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [fis_pkg::RAD_W-1:0]  i_radicand,
    output logic                    o_busy,
    output logic [fis_pkg::ROOT_W-1:0] o_root
);

    logic [fis_pkg::RAD_W-1:0]  r_d;
    logic [47:0]                r_rem;
    logic [fis_pkg::ROOT_W-1:0] r_root;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic [47:0]                rem_s;
    logic [47:0]                trial;
    logic                       ge;

    assign rem_s = {r_rem[45:0], r_d[91:90]};
    assign trial = {r_root, 2'b01};
    assign ge = rem_s >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'(fis_pkg::ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= i_radicand;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_d <= {r_d[89:0], 2'b00};
            r_rem <= ge ? rem_s - trial : rem_s;
            r_root <= {r_root[44:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== hdl/fis_dp.sv =====
module fis_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fis_pkg::t_cmd  i_cmd,
    output fis_pkg::t_sts  o_sts,
    input  fis_pkg::t_in   i_in_data,
    input  logic [9:0]     i_target_fps,
    input  logic           i_vsync_enabled,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fis_pkg::t_out  o_out_data
);

    logic [23:0] mem [fis_pkg::DEPTH];
    logic [fis_pkg::DEPTH-1:0] r_vld;
    logic [fis_pkg::SLOT_W-1:0] r_slot;
    logic [23:0] r_rd;
    logic        r_rd_vld;
    logic [23:0] r_iv;
    logic [23:0] r_busy;
    logic [23:0] r_old;
    logic [59:0] r_prod;
    logic [29:0] r_sum;
    logic [53:0] r_sq;
    logic [27:0] r_q_cur;
    logic [27:0] r_q_avg;
    logic [19:0] r_q_per;
    logic [19:0] r_q_pac;
    logic        r_out_valid;
    fis_pkg::t_out r_out;

    logic [23:0] old;
    logic [59:0] nsq;
    logic [59:0] dev;
    logic [23:0] avg;
    logic [45:0] d_dividend;
    logic [29:0] d_divisor;
    logic [4:0]  d_nbits;
    logic        div_done;
    logic [27:0] quot;
    logic        sqrt_busy;
    logic [45:0] root;
    logic        wait_en;
    fis_pkg::t_out res;

    assign old = r_rd_vld ? r_rd : 24'd0;
    assign nsq = {r_sq, 6'b0};
    assign dev = (nsq >= r_prod) ? nsq - r_prod : 60'd0;
    assign avg = r_sum[29:6];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= mem[r_slot];
        end
        if (i_cmd.upd_sum) begin
            mem[r_slot] <= r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_slot <= '0;
            r_sum <= '0;
            r_sq <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.upd_sum) begin
                r_vld[r_slot] <= 1'b1;
                r_slot <= r_slot + {{(fis_pkg::SLOT_W-1){1'b0}}, 1'b1};
                r_sum <= r_sum - 30'(r_old) + 30'(r_iv);
                r_sq <= r_sq - r_prod[53:0];
            end
            if (i_cmd.add_sq) begin
                r_sq <= r_sq + r_prod[53:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_iv <= i_in_data.interval_us;
            r_busy <= i_in_data.busy_us;
            r_rd_vld <= r_vld[r_slot];
        end
        if (i_cmd.mul_old) begin
            r_old <= old;
            r_prod <= 60'(old * old);
        end
        if (i_cmd.upd_sum) begin
            r_prod <= 60'(r_iv * r_iv);
        end
        if (i_cmd.mul_sum) begin
            r_prod <= 60'(r_sum * r_sum);
        end
        if (div_done) begin
            case (i_cmd.op)
                fis_pkg::OP_CUR: r_q_cur <= quot;
                fis_pkg::OP_AVG: r_q_avg <= quot;
                fis_pkg::OP_PER: r_q_per <= quot[19:0];
                fis_pkg::OP_PAC: r_q_pac <= quot[19:0];
                default: r_q_cur <= quot;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    always_comb begin
        case (i_cmd.op)
            fis_pkg::OP_CUR: begin
                d_dividend = 46'(fis_pkg::RATE_SCALE);
                d_divisor = 30'(r_iv);
                d_nbits = fis_pkg::NB_RATE;
            end
            fis_pkg::OP_AVG: begin
                d_dividend = 46'(fis_pkg::RATE_SCALE);
                d_divisor = 30'(avg);
                d_nbits = fis_pkg::NB_RATE;
            end
            fis_pkg::OP_PER: begin
                d_dividend = 46'(fis_pkg::USEC_PER_SEC);
                d_divisor = 30'(i_target_fps);
                d_nbits = fis_pkg::NB_SHORT;
            end
            default: begin
                d_dividend = root;
                d_divisor = r_sum;
                d_nbits = fis_pkg::NB_SHORT;
            end
        endcase
    end

    fis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (d_dividend),
        .i_divisor  (d_divisor),
        .i_nbits    (d_nbits),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    fis_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand ({dev, 32'b0}),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    assign wait_en = !i_vsync_enabled && (i_target_fps != 10'd0);

    always_comb begin
        res.frame_time_us = r_iv;
        res.current_fps_q8 = (r_iv == 24'd0) ? fis_pkg::RATE_SCALE : r_q_cur;
        res.average_time_us = avg;
        res.average_fps_q8 = (avg == 24'd0) ? fis_pkg::RATE_SCALE : r_q_avg;
        if (r_sum == 30'd0 || r_q_pac >= 20'(fis_pkg::Q_ONE)) begin
            res.pacing_quality = 17'd0;
        end else begin
            res.pacing_quality = fis_pkg::Q_ONE - 17'(r_q_pac);
        end
        if (wait_en && ({4'b0, r_q_per} > r_busy)) begin
            res.wait_us = r_q_per - r_busy[19:0];
        end else begin
            res.wait_us = 20'd0;
        end
        res.divide_by_zero = (r_iv == 24'd0) || (avg == 24'd0);
    end

    assign o_sts.sqrt_done = !sqrt_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

// ===== hdl/fis_ctrl.sv =====
module fis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fis_pkg::t_sts i_sts,
    output fis_pkg::t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RD     = 9'b000000010,
        S_SQO    = 9'b000000100,
        S_SQN    = 9'b000001000,
        S_SSQ    = 9'b000010000,
        S_DEV    = 9'b000100000,
        S_DSTART = 9'b001000000,
        S_DWAIT  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    fis_pkg::t_op r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= fis_pkg::OP_CUR;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        o_cmd = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.mul_old = 1'b1;
                n_state = S_SQO;
            end
            S_SQO: begin
                o_cmd.upd_sum = 1'b1;
                n_state = S_SQN;
            end
            S_SQN: begin
                o_cmd.add_sq = 1'b1;
                n_state = S_SSQ;
            end
            S_SSQ: begin
                o_cmd.mul_sum = 1'b1;
                n_state = S_DEV;
            end
            S_DEV: begin
                o_cmd.sqrt_start = 1'b1;
                n_op = fis_pkg::OP_CUR;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                if (r_op != fis_pkg::OP_PAC || i_sts.sqrt_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    case (r_op)
                        fis_pkg::OP_CUR: begin
                            n_op = fis_pkg::OP_AVG;
                            n_state = S_DSTART;
                        end
                        fis_pkg::OP_AVG: begin
                            n_op = fis_pkg::OP_PER;
                            n_state = S_DSTART;
                        end
                        fis_pkg::OP_PER: begin
                            n_op = fis_pkg::OP_PAC;
                            n_state = S_DSTART;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hdl/frame_interval_statistics_top.sv =====
// throughput: one item at a time, set by the shared iterative divider
// (28 + 28 + 20 + 20 steps); the 46-step square root runs beside it
// a waiting result beat does not block the next input beat
// reset: synchronous active low, clears history valid bits, sums, output valid and the target and vsync registers
module frame_interval_statistics_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fis_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fis_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [9:0]    r_target_fps;
    logic          r_vsync_enabled;
    fis_pkg::t_cmd cmd;
    fis_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_fps <= '0;
            r_vsync_enabled <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                fis_pkg::REG_TARGET: r_target_fps <= pwdata[9:0];
                fis_pkg::REG_VSYNC: r_vsync_enabled <= pwdata[0];
                default: r_target_fps <= r_target_fps;
            endcase
        end
    end

    assign prdata = (paddr[2] == fis_pkg::REG_VSYNC) ? {31'b0, r_vsync_enabled}
                                                     : {22'b0, r_target_fps};
    assign pready = 1'b1;

    fis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fis_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_data       (i_in_data),
        .i_target_fps    (r_target_fps),
        .i_vsync_enabled (r_vsync_enabled),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_data      (o_out_data)
    );

endmodule

// ===== hdl/fis_checker.sv =====
module fis_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input fis_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input fis_pkg::t_out o_out_data,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_time_us == 24'd0 |->
        o_out_data.divide_by_zero && o_out_data.current_fps_q8 == fis_pkg::RATE_SCALE)
        else $error("zero interval not saturated");

    a_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pacing_quality <= fis_pkg::Q_ONE)
        else $error("pacing quality out of range");

endmodule

bind frame_interval_statistics_top fis_checker u_chk (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PER_PHASE = 240;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    fis_pkg::t_in   i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    fis_pkg::t_out  o_out_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    frame_interval_statistics_top dut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct {
        logic [23:0] iv;
        logic [23:0] busy;
        bit          has_fps;
        logic [27:0] fps;
        bit          has_dz;
        logic        dz;
    } t_row;

    // model of the block
    logic [23:0] hist [fis_pkg::DEPTH];
    int unsigned slot;
    logic [63:0] win_sum;
    logic [63:0] win_sq;
    logic [9:0]  tgt_fps;
    logic        vsync;

    fis_pkg::t_out pending_frames [$];
    int            mismatches = 0;
    int            cycles = 0;
    int unsigned   results_seen = 0;
    bit            no_gaps = 0;
    bit            hold_armed = 0;

    function automatic logic [16:0] pacing_of(logic [63:0] s, logic [63:0] sq);
        logic [127:0] nsq, ssq, dev, p;
        logic [16:0]  r, cand;
        r = '0;
        if (s == 0) return '0;
        nsq = 128'(sq) * fis_pkg::DEPTH;
        ssq = 128'(s) * 128'(s);
        dev = (nsq >= ssq) ? nsq - ssq : '0;
        dev = dev << 32;
        for (int b = 16; b >= 0; b--) begin
            cand = r | (17'd1 << b);
            if (cand > fis_pkg::Q_ONE) continue;
            p = 128'(cand) * 128'(s);
            if (dev >= p * p) r = cand;
        end
        return fis_pkg::Q_ONE - r;
    endfunction

    function automatic fis_pkg::t_out frame_stats(fis_pkg::t_in d);
        fis_pkg::t_out o;
        logic [23:0]   old;
        logic [63:0]   avg, period;
        old = hist[slot];
        hist[slot] = d.interval_us;
        win_sum = win_sum - old + d.interval_us;
        win_sq = win_sq - 64'(old) * old + 64'(d.interval_us) * d.interval_us;
        slot = (slot + 1) % fis_pkg::DEPTH;
        o.frame_time_us = d.interval_us;
        o.divide_by_zero = 1'b0;
        if (d.interval_us == 0) begin
            o.current_fps_q8 = fis_pkg::RATE_SCALE;
            o.divide_by_zero = 1'b1;
        end else begin
            o.current_fps_q8 = 28'(64'(fis_pkg::RATE_SCALE) / d.interval_us);
        end
        avg = (win_sum / fis_pkg::DEPTH) & 64'hFFFFFF;
        o.average_time_us = avg[23:0];
        if (avg == 0) begin
            o.average_fps_q8 = fis_pkg::RATE_SCALE;
            o.divide_by_zero = 1'b1;
        end else begin
            o.average_fps_q8 = 28'(64'(fis_pkg::RATE_SCALE) / avg);
        end
        o.pacing_quality = pacing_of(win_sum, win_sq);
        o.wait_us = '0;
        if (!vsync && tgt_fps != 0) begin
            period = 64'(fis_pkg::USEC_PER_SEC) / tgt_fps;
            if (period > d.busy_us) o.wait_us = 20'(period - d.busy_us);
        end
        return o;
    endfunction

    task automatic reg_write(logic idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == fis_pkg::REG_TARGET) tgt_fps = val[9:0];
        else vsync = val[0];
    endtask

    task automatic send_frame(fis_pkg::t_in d, bit has_fps, logic [27:0] fps, bit has_dz,
                              logic dz);
        int            gap;
        fis_pkg::t_out e;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        e = frame_stats(d);
        if (has_fps) e.current_fps_q8 = fps;
        if (has_dz) e.divide_by_zero = dz;
        pending_frames.push_back(e);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    function automatic fis_pkg::t_in random_frame(int mode, logic [23:0] base);
        fis_pkg::t_in d;
        case (mode)
            0: d.interval_us = base + 24'($urandom_range(0, 200));
            1: d.interval_us = 24'($urandom_range(1000, 100000));
            2: d.interval_us = 24'($urandom);
            default: d.interval_us = ($urandom_range(0, 3) == 0) ? 24'd0
                                     : 24'($urandom_range(0, 20));
        endcase
        case ($urandom_range(0, 3))
            0: d.busy_us = 24'($urandom);
            1: d.busy_us = 24'($urandom_range(0, 10));
            default: d.busy_us = 24'($urandom_range(0, 40000));
        endcase
        return d;
    endfunction

    task automatic compare_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, e, a);
        end
    endtask

    // result side
    initial begin
        int            n;
        fis_pkg::t_out e;
        @(posedge i_rst_n);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 9);
            if (hold_armed) begin
                n = HOLD_CYCLES;
                hold_armed = 0;
            end
            @(negedge i_clk);
            i_out_stall <= (n > 0);
            if (n > 0) begin
                do @(posedge i_clk); while (!o_out_valid);
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            results_seen++;
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                e = pending_frames.pop_front();
                compare_field("frame_time_us", e.frame_time_us, o_out_data.frame_time_us);
                compare_field("current_fps_q8", e.current_fps_q8,
                              o_out_data.current_fps_q8);
                compare_field("average_time_us", e.average_time_us,
                              o_out_data.average_time_us);
                compare_field("average_fps_q8", e.average_fps_q8,
                              o_out_data.average_fps_q8);
                compare_field("pacing_quality", e.pacing_quality,
                              o_out_data.pacing_quality);
                compare_field("wait_us", e.wait_us, o_out_data.wait_us);
                compare_field("divide_by_zero", e.divide_by_zero,
                              o_out_data.divide_by_zero);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row         rows [$];
        logic [9:0]   tgts [6];
        logic         vsyncs [6];
        int           mode;
        logic [23:0]  base;
        fis_pkg::t_in d;

        rows = '{
            '{24'd0,        24'd0,        1, 28'd256000000, 1, 1'b1},
            '{24'hFFFFFF,   24'hFFFFFF,   1, 28'd15,        0, 1'b0},
            '{24'd1,        24'd0,        1, 28'd256000000, 0, 1'b0},
            '{24'd16667,    24'd5000,     0, '0,            0, 1'b0},
            '{24'd0,        24'h555555,   1, 28'd256000000, 1, 1'b1},
            '{24'hAAAAAA,   24'hAAAAAA,   0, '0,            0, 1'b0},
            '{24'h555555,   24'h000001,   0, '0,            0, 1'b0},
            '{24'd1000,     24'd999,      1, 28'd256000,    0, 1'b0},
            '{24'd256000,   24'd0,        1, 28'd1000,      0, 1'b0},
            '{24'd33333,    24'hFFFFFF,   0, '0,            0, 1'b0}
        };
        tgts = '{10'd0, 10'd60, 10'd1023, 10'd1, 10'd144, 10'd1000};
        vsyncs = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

        for (int i = 0; i < fis_pkg::DEPTH; i++) hist[i] = '0;
        slot = 0;
        win_sum = '0;
        win_sq = '0;
        tgt_fps = '0;
        vsync = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            d.interval_us = rows[i].iv;
            d.busy_us = rows[i].busy;
            send_frame(d, rows[i].has_fps, rows[i].fps, rows[i].has_dz, rows[i].dz);
        end
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            reg_write(fis_pkg::REG_TARGET, 32'(tgts[ph]));
            reg_write(fis_pkg::REG_VSYNC, 32'(vsyncs[ph]));
            if (ph == 2) hold_armed = 1;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k % 80 == 0) begin
                    mode = $urandom_range(0, 3);
                    base = 24'($urandom_range(1000, 60000));
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                send_frame(random_frame(mode, base), 0, '0, 0, 1'b0);
            end
            no_gaps = 0;
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/fis_pkg.sv
hdl/fis_div.sv
hdl/fis_sqrt.sv
hdl/fis_dp.sv
hdl/fis_ctrl.sv
hdl/frame_interval_statistics_top.sv
hdl/fis_checker.sv
tb/tb_top.sv
